### rtl/pidc_pkg.sv
package pidc_pkg;

  localparam int FRAC_BITS   = 12;
  localparam int ERROR_WIDTH = 16;

  localparam int MODE_W   = 2;
  localparam int GAIN_W   = 24;
  localparam int IGAIN_W  = 23;
  localparam int LIMIT_W  = 31;
  localparam int DRIVE_W  = 32;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = LIMIT_W;

  localparam int IN_TDATA_W  = ((ERROR_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DRIVE_W + 7) / 8) * 8;

  // product and accumulator widths
  localparam int DIFF_W  = ERROR_WIDTH + 1;
  localparam int P_W     = GAIN_W + ERROR_WIDTH;
  localparam int I_W     = IGAIN_W + 1 + ERROR_WIDTH;
  localparam int D_W     = GAIN_W + DIFF_W;
  localparam int INTEG_W = LIMIT_W + FRAC_BITS + 1;
  localparam int ACC_W   = ((INTEG_W > I_W) ? INTEG_W : I_W) + 1;
  localparam int SUM_W   = ((INTEG_W > D_W) ? INTEG_W : D_W) + 2;
  localparam int SHIFT_W = SUM_W - FRAC_BITS;
  localparam int CMP_W   = (SHIFT_W > DRIVE_W) ? SHIFT_W : DRIVE_W + 1;

  localparam logic [MODE_W-1:0] MODE_PID = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PI  = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_P = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_I = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_OLIMIT = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_ILIMIT = 3'd5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [GAIN_W-1:0]  gain_p;
    logic [IGAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [LIMIT_W-1:0] out_limit;
    logic [LIMIT_W-1:0] integral_limit;
  } cfg_t;

  typedef struct packed {
    logic use_i;
    logic use_d;
  } law_t;

endpackage

### rtl/pid_controller_with_clamps_unit.sv
// pipeline: a word accepted on the input passes through these registers in order
// (input reg, product reg, integral reg, result reg)
// throughput: one word per cycle while out_tready does not stall; the integral loop is a single add and clamp
// stalls on out_tready back up stage by stage, empty stages still fill
// reset: synchronous active-low rst_n clears the pipeline, the integral and the
// previous error, and loads mode PID, zero gains and both limits at full scale
module pid_controller_with_clamps_unit
  import pidc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // error_sample
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // drive
  output logic                   out_tuser,  // saturated
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t                    cfg;
  logic                    fb_valid;
  logic                    fb_ready;
  logic signed [P_W-1:0]   p_prod;
  logic signed [I_W-1:0]   i_prod;
  logic signed [D_W-1:0]   d_prod;
  law_t                    law;
  logic                    io_valid;
  logic                    io_ready;
  logic signed [SUM_W-1:0] pd_term;
  logic signed [SUM_W-1:0] i_term;
  logic [DRIVE_W-1:0]      drive;

  pidc_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pidc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_error  ($signed(in_tdata[ERROR_WIDTH-1:0])),
    .out_valid (fb_valid),
    .out_ready (fb_ready),
    .p_prod    (p_prod),
    .i_prod    (i_prod),
    .d_prod    (d_prod),
    .law       (law)
  );

  pidc_integ u_integ (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (fb_valid),
    .in_ready  (fb_ready),
    .p_prod    (p_prod),
    .i_prod    (i_prod),
    .d_prod    (d_prod),
    .law       (law),
    .out_valid (io_valid),
    .out_ready (io_ready),
    .pd_term   (pd_term),
    .i_term    (i_term)
  );

  pidc_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (io_valid),
    .in_ready  (io_ready),
    .pd_term   (pd_term),
    .i_term    (i_term),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .drive     (drive),
    .saturated (out_tuser)
  );

  assign out_tdata = OUT_TDATA_W'(drive);

endmodule

### rtl/pidc_regs.sv
module pidc_regs
  import pidc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode           <= MODE_PID;
      cfg_r.gain_p         <= '0;
      cfg_r.gain_i         <= '0;
      cfg_r.gain_d         <= '0;
      cfg_r.out_limit      <= LIMIT_RESET;
      cfg_r.integral_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MODE:   cfg_r.mode           <= cfg_wdata[MODE_W-1:0];
        REG_GAIN_P: cfg_r.gain_p         <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I: cfg_r.gain_i         <= cfg_wdata[IGAIN_W-1:0];
        REG_GAIN_D: cfg_r.gain_d         <= cfg_wdata[GAIN_W-1:0];
        REG_OLIMIT: cfg_r.out_limit      <= cfg_wdata[LIMIT_W-1:0];
        REG_ILIMIT: cfg_r.integral_limit <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/pidc_front.sv
module pidc_front
  import pidc_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfg_t                          cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [ERROR_WIDTH-1:0] in_error,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [P_W-1:0]         p_prod,
  output logic signed [I_W-1:0]         i_prod,
  output logic signed [D_W-1:0]         d_prod,
  output law_t                          law
);

  logic                          a_valid_r;
  logic signed [ERROR_WIDTH-1:0] e_r;
  logic signed [ERROR_WIDTH-1:0] prev_r;
  logic                          b_valid_r;
  logic signed [P_W-1:0]         p_prod_r;
  logic signed [I_W-1:0]         i_prod_r;
  logic signed [D_W-1:0]         d_prod_r;
  law_t                          law_r;

  logic                          a_ready;
  logic                          b_ready;
  logic signed [DIFF_W-1:0]      diff;
  logic signed [P_W-1:0]         p_prod_nxt;
  logic signed [I_W-1:0]         i_prod_nxt;
  logic signed [D_W-1:0]         d_prod_nxt;
  law_t                          law_nxt;

  assign b_ready = !b_valid_r || out_ready;
  assign a_ready = !a_valid_r || b_ready;

  always_comb begin
    law_nxt.use_i = (cfg.mode != MODE_PD);
    law_nxt.use_d = (cfg.mode != MODE_PI);
    diff       = DIFF_W'(e_r) - DIFF_W'(prev_r);
    p_prod_nxt = P_W'($signed(cfg.gain_p)) * P_W'(e_r);
    i_prod_nxt = I_W'($signed({1'b0, cfg.gain_i})) * I_W'(e_r);
    d_prod_nxt = D_W'($signed(cfg.gain_d)) * D_W'(diff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      prev_r    <= '0;
    end else begin
      if (a_ready) begin
        a_valid_r <= in_valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
      // previous error only moves on when the difference term is in use
      if (a_valid_r && b_ready && law_nxt.use_d) begin
        prev_r <= e_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      e_r <= in_error;
    end
    if (a_valid_r && b_ready) begin
      p_prod_r <= p_prod_nxt;
      i_prod_r <= i_prod_nxt;
      d_prod_r <= d_prod_nxt;
      law_r    <= law_nxt;
    end
  end

  assign in_ready  = a_ready;
  assign out_valid = b_valid_r;
  assign p_prod    = p_prod_r;
  assign i_prod    = i_prod_r;
  assign d_prod    = d_prod_r;
  assign law       = law_r;

endmodule

### rtl/pidc_integ.sv
module pidc_integ
  import pidc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [P_W-1:0]   p_prod,
  input  logic signed [I_W-1:0]   i_prod,
  input  logic signed [D_W-1:0]   d_prod,
  input  law_t                    law,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SUM_W-1:0] pd_term,
  output logic signed [SUM_W-1:0] i_term
);

  logic                      c_valid_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [SUM_W-1:0]   pd_r;
  logic signed [SUM_W-1:0]   ival_r;

  logic                      c_ready;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   lim;
  logic signed [ACC_W-1:0]   clamped;
  logic signed [INTEG_W-1:0] integ_nxt;
  logic signed [SUM_W-1:0]   pd_nxt;
  logic signed [SUM_W-1:0]   ival_nxt;

  assign c_ready = !c_valid_r || out_ready;

  always_comb begin
    acc = ACC_W'(integ_r) + ACC_W'(i_prod);
    lim = $signed(ACC_W'({cfg.integral_limit, FRAC_BITS'(0)}));
    // anti-windup clamp on the gain-scaled integral
    if (acc > lim) begin
      clamped = lim;
    end else if (acc < -lim) begin
      clamped = -lim;
    end else begin
      clamped = acc;
    end
    integ_nxt = INTEG_W'(clamped);
    ival_nxt  = law.use_i ? SUM_W'(integ_nxt) : '0;
    pd_nxt    = SUM_W'(p_prod) + (law.use_d ? SUM_W'(d_prod) : SUM_W'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      integ_r   <= '0;
    end else begin
      if (c_ready) begin
        c_valid_r <= in_valid;
      end
      if (in_valid && c_ready && law.use_i) begin
        integ_r <= integ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && c_ready) begin
      pd_r   <= pd_nxt;
      ival_r <= ival_nxt;
    end
  end

  assign in_ready  = c_ready;
  assign out_valid = c_valid_r;
  assign pd_term   = pd_r;
  assign i_term    = ival_r;

endmodule

### rtl/pidc_out.sv
module pidc_out
  import pidc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [SUM_W-1:0] pd_term,
  input  logic signed [SUM_W-1:0] i_term,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [DRIVE_W-1:0]      drive,
  output logic                    saturated
);

  logic                      d_valid_r;
  logic [DRIVE_W-1:0]        drive_r;
  logic                      sat_r;

  logic                      d_ready;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SHIFT_W-1:0] y;
  logic signed [CMP_W-1:0]   y_ext;
  logic signed [CMP_W-1:0]   lim;
  logic [DRIVE_W-1:0]        drive_nxt;
  logic                      sat_nxt;

  assign d_ready = !d_valid_r || out_ready;

  always_comb begin
    sum   = pd_term + i_term;
    // dropping the fraction bits rounds toward minus infinity
    y     = sum[SUM_W-1:FRAC_BITS];
    y_ext = CMP_W'(y);
    lim   = $signed(CMP_W'(cfg.out_limit));
    if (y_ext > lim) begin
      drive_nxt = DRIVE_W'(lim);
      sat_nxt   = 1'b1;
    end else if (y_ext < -lim) begin
      drive_nxt = DRIVE_W'(-lim);
      sat_nxt   = 1'b1;
    end else begin
      drive_nxt = DRIVE_W'(y_ext);
      sat_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (d_ready) begin
      d_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && d_ready) begin
      drive_r <= drive_nxt;
      sat_r   <= sat_nxt;
    end
  end

  assign in_ready  = d_ready;
  assign out_valid = d_valid_r;
  assign drive     = drive_r;
  assign saturated = sat_r;

endmodule

### rtl/pidc_checker.sv
module pidc_checker
  import pidc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  localparam logic [DRIVE_W-1:0] MOST_NEG = {1'b1, {(DRIVE_W - 1){1'b0}}};

  // a stalled result word holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output word changed");

  // nothing comes out of a freshly reset pipeline
  assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid)
    else $error("output valid right after reset");

  // an empty output register means every stage behind it can move
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output empty");

  // symmetric saturation never yields the most negative code
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[DRIVE_W-1:0] != MOST_NEG)
    else $error("drive outside symmetric range");

endmodule

bind pid_controller_with_clamps_unit pidc_checker u_pidc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
